[hdl/assert_macros.svh]
// Assertion macros shared by the temperature color ramp RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCR_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("temperature color ramp assertion failed");

// implication in the next cycle
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("temperature color ramp assertion failed");

// implication delayed by the dly argument
`define TCR_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("temperature color ramp assertion failed");

`endif

[hdl/tcr_pkg.sv]
// Shared types and constants of the temperature color ramp
`timescale 1ns / 1ps

package tcr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TEMP_W        = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int SPAN_W        = 16;
  localparam int COLOR_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMFORT_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMFORT_HIGH = 2'd3;

  localparam logic signed [TEMP_W-1:0] SCALE_LOW_RST    = 16'sd0;
  localparam logic signed [TEMP_W-1:0] SCALE_HIGH_RST   = 16'sd1600;
  localparam logic signed [TEMP_W-1:0] COMFORT_LOW_RST  = 16'sd1088;
  localparam logic signed [TEMP_W-1:0] COMFORT_HIGH_RST = 16'sd1232;

  typedef enum logic [2:0] {
    RG_LOW  = 3'b001,
    RG_MID  = 3'b010,
    RG_HIGH = 3'b100
  } region_e;

  typedef enum logic [2:0] {
    FM_DIV  = 3'b001,
    FM_ZERO = 3'b010,
    FM_ONE  = 3'b100
  } fmode_e;

  typedef struct packed {
    logic    valid;
    region_e region;
    fmode_e  fmode;
  } ctl_t;

endpackage

[hdl/tcr_div_cell.sv]
// One restoring-division cell: one quotient bit per request per cycle
`timescale 1ns / 1ps

module tcr_div_cell #(
  parameter int FRAC_BITS = tcr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcr_pkg::ctl_t               ctl_i,
  input  logic [tcr_pkg::SPAN_W-1:0]  span_i,
  input  logic [tcr_pkg::SPAN_W-1:0]  rem_i,
  input  logic [FRAC_BITS-1:0]        quot_i,
  output tcr_pkg::ctl_t               ctl_o,
  output logic [tcr_pkg::SPAN_W-1:0]  span_o,
  output logic [tcr_pkg::SPAN_W-1:0]  rem_o,
  output logic [FRAC_BITS-1:0]        quot_o
);

  tcr_pkg::ctl_t               ctl_q;
  logic [tcr_pkg::SPAN_W-1:0]  span_q, rem_q, rem_d;
  logic [FRAC_BITS-1:0]        quot_q, quot_d;
  logic [tcr_pkg::SPAN_W:0]    rem2, diff;
  logic                        ge;

  always_comb begin
    rem2   = {rem_i, 1'b0};
    diff   = rem2 - {1'b0, span_i};
    ge     = rem2 >= {1'b0, span_i};
    rem_d  = ge ? diff[tcr_pkg::SPAN_W-1:0] : rem2[tcr_pkg::SPAN_W-1:0];
    quot_d = {quot_i[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_i;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign ctl_o  = ctl_q;
  assign span_o = span_q;
  assign rem_o  = rem_q;
  assign quot_o = quot_q;

endmodule

[hdl/tcr_prep.sv]
// Band clamping, ramp selection and divider operand setup
`timescale 1ns / 1ps

module tcr_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [tcr_pkg::TEMP_W-1:0]  temperature_i,
  input  logic signed [tcr_pkg::TEMP_W-1:0]  scale_low_i,
  input  logic signed [tcr_pkg::TEMP_W-1:0]  scale_high_i,
  input  logic signed [tcr_pkg::TEMP_W-1:0]  comfort_low_i,
  input  logic signed [tcr_pkg::TEMP_W-1:0]  comfort_high_i,
  output tcr_pkg::ctl_t                      ctl_o,
  output logic [tcr_pkg::SPAN_W-1:0]         span_o,
  output logic [tcr_pkg::SPAN_W-1:0]         rem_o
);

  localparam int DW = tcr_pkg::TEMP_W + 1;

  logic                              va_q, vb_q;
  logic signed [tcr_pkg::TEMP_W-1:0] t_q;
  logic signed [tcr_pkg::TEMP_W-1:0] clo, chi, base;
  logic signed [DW-1:0]              span_raw, num_d, num_q;
  logic [tcr_pkg::SPAN_W-1:0]        span_d, span_q;
  tcr_pkg::region_e                  region_d, region_q;
  tcr_pkg::ctl_t                     ctl_d, ctl_q;
  logic [tcr_pkg::SPAN_W-1:0]        span_c_q, rem_q;

  always_comb begin
    if (comfort_low_i < scale_low_i) begin
      clo = scale_low_i;
    end else if (comfort_low_i > scale_high_i) begin
      clo = scale_high_i;
    end else begin
      clo = comfort_low_i;
    end
    if (comfort_high_i < clo) begin
      chi = clo;
    end else if (comfort_high_i > scale_high_i) begin
      chi = scale_high_i;
    end else begin
      chi = comfort_high_i;
    end
    if (t_q <= clo) begin
      region_d = tcr_pkg::RG_LOW;
      base     = scale_low_i;
      span_raw = DW'(clo) - DW'(scale_low_i);
    end else if (t_q >= chi) begin
      region_d = tcr_pkg::RG_HIGH;
      base     = chi;
      span_raw = DW'(scale_high_i) - DW'(chi);
    end else begin
      region_d = tcr_pkg::RG_MID;
      base     = chi;
      span_raw = DW'(scale_high_i) - DW'(chi);
    end
    span_d = (span_raw < DW'(1)) ? tcr_pkg::SPAN_W'(1) : span_raw[tcr_pkg::SPAN_W-1:0];
    num_d  = DW'(t_q) - DW'(base);
  end

  always_comb begin
    ctl_d.valid  = vb_q;
    ctl_d.region = region_q;
    if (num_q <= DW'(0)) begin
      ctl_d.fmode = tcr_pkg::FM_ZERO;
    end else if (num_q >= $signed({1'b0, span_q})) begin
      ctl_d.fmode = tcr_pkg::FM_ONE;
    end else begin
      ctl_d.fmode = tcr_pkg::FM_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      region_q <= tcr_pkg::RG_MID;
      ctl_q    <= '0;
    end else begin
      va_q     <= valid_i;
      vb_q     <= va_q;
      region_q <= region_d;
      ctl_q    <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= temperature_i;
    span_q   <= span_d;
    num_q    <= num_d;
    span_c_q <= span_q;
    rem_q    <= num_q[tcr_pkg::SPAN_W-1:0];
  end

  assign ctl_o  = ctl_q;
  assign span_o = span_c_q;
  assign rem_o  = rem_q;

endmodule

[hdl/tcr_mix.sv]
// Channel interpolation between color stops and RGB565 packing
`timescale 1ns / 1ps

module tcr_mix #(
  parameter int FRAC_BITS = tcr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcr_pkg::ctl_t                ctl_i,
  input  logic [FRAC_BITS-1:0]         quot_i,
  output logic                         done_o,
  output logic [tcr_pkg::COLOR_W-1:0]  color_o
);

  localparam int PW = FRAC_BITS + 11;

  localparam logic [7:0] BLUE_R  = 8'd40;
  localparam logic [7:0] BLUE_G  = 8'd90;
  localparam logic [7:0] BLUE_B  = 8'd230;
  localparam logic [7:0] GREEN_R = 8'd40;
  localparam logic [7:0] GREEN_G = 8'd200;
  localparam logic [7:0] GREEN_B = 8'd80;
  localparam logic [7:0] RED_R   = 8'd210;
  localparam logic [7:0] RED_G   = 8'd40;
  localparam logic [7:0] RED_B   = 8'd30;

  function automatic logic [7:0] mix_ch(logic [7:0] a, logic [7:0] b, logic [FRAC_BITS:0] f);
    logic signed [PW-1:0] a_s, d_s, f_s, acc;
    a_s = PW'($signed({1'b0, a}));
    d_s = PW'($signed({1'b0, b}) - $signed({1'b0, a}));
    f_s = PW'($signed({1'b0, f}));
    acc = (a_s <<< FRAC_BITS) + d_s * f_s;
    return acc[FRAC_BITS+7:FRAC_BITS];
  endfunction

  logic [FRAC_BITS:0]          f;
  logic [7:0]                  a_r, a_g, a_b, b_r, b_g, b_b, r, g, b;
  logic [tcr_pkg::COLOR_W-1:0] color_d, color_q;
  logic                        done_q;

  always_comb begin
    case (ctl_i.fmode)
      tcr_pkg::FM_ZERO: f = '0;
      tcr_pkg::FM_ONE:  f = {1'b1, {FRAC_BITS{1'b0}}};
      default:          f = {1'b0, quot_i};
    endcase
    case (ctl_i.region)
      tcr_pkg::RG_LOW: begin
        a_r = BLUE_R;  a_g = BLUE_G;  a_b = BLUE_B;
        b_r = GREEN_R; b_g = GREEN_G; b_b = GREEN_B;
      end
      tcr_pkg::RG_HIGH: begin
        a_r = GREEN_R; a_g = GREEN_G; a_b = GREEN_B;
        b_r = RED_R;   b_g = RED_G;   b_b = RED_B;
      end
      default: begin
        a_r = GREEN_R; a_g = GREEN_G; a_b = GREEN_B;
        b_r = GREEN_R; b_g = GREEN_G; b_b = GREEN_B;
      end
    endcase
    r       = mix_ch(a_r, b_r, f);
    g       = mix_ch(a_g, b_g, f);
    b       = mix_ch(a_b, b_b, f);
    color_d = {r[7:3], g[7:2], b[7:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign done_o  = done_q;
  assign color_o = color_q;

endmodule

[hdl/temperature_color_ramp_core.sv]
// Top level of the temperature to RGB565 false-color ramp
//
// Usage: drive temperature_i (signed, 1/16 degree F) with start_i high for
// one cycle per request; busy_o stays low, so a request is taken in every
// cycle that start_i is high. Each request yields exactly one color: done_o
// pulses for one cycle with color_rgb565_o valid in that cycle, in request
// order. Throughput is one request per cycle. The divider is a chain of
// FRAC_BITS cells, each resolving one fraction bit of (t - base) / span per
// cycle; the setup stages in tcr_prep come before it and the output
// register in tcr_mix comes after it.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
// (0 scale_low, 1 scale_high, 2 comfort_low, 3 comfort_high); write only
// while no request is in flight. Reset clears all requests in flight and
// loads the default scale 0..1600 with comfort band 1088..1232.
// The receiver cannot stall: results must be taken when done_o is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module temperature_color_ramp_core #(
  parameter int FRAC_BITS = tcr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [tcr_pkg::TEMP_W-1:0]   temperature_i,
  output logic                                done_o,
  output logic [tcr_pkg::COLOR_W-1:0]         color_rgb565_o,
  input  logic                                cfg_we_i,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tcr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int LATENCY = FRAC_BITS + 4;

  logic signed [tcr_pkg::TEMP_W-1:0] scale_low_q, scale_high_q;
  logic signed [tcr_pkg::TEMP_W-1:0] comfort_low_q, comfort_high_q;

  tcr_pkg::ctl_t              ctl_c  [FRAC_BITS+1];
  logic [tcr_pkg::SPAN_W-1:0] span_c [FRAC_BITS+1];
  logic [tcr_pkg::SPAN_W-1:0] rem_c  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]       quot_c [FRAC_BITS+1];

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_low_q    <= tcr_pkg::SCALE_LOW_RST;
      scale_high_q   <= tcr_pkg::SCALE_HIGH_RST;
      comfort_low_q  <= tcr_pkg::COMFORT_LOW_RST;
      comfort_high_q <= tcr_pkg::COMFORT_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcr_pkg::CFG_SCALE_LOW:    scale_low_q    <= $signed(cfg_wdata_i);
        tcr_pkg::CFG_SCALE_HIGH:   scale_high_q   <= $signed(cfg_wdata_i);
        tcr_pkg::CFG_COMFORT_LOW:  comfort_low_q  <= $signed(cfg_wdata_i);
        tcr_pkg::CFG_COMFORT_HIGH: comfort_high_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  tcr_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .temperature_i  (temperature_i),
    .scale_low_i    (scale_low_q),
    .scale_high_i   (scale_high_q),
    .comfort_low_i  (comfort_low_q),
    .comfort_high_i (comfort_high_q),
    .ctl_o          (ctl_c[0]),
    .span_o         (span_c[0]),
    .rem_o          (rem_c[0])
  );

  assign quot_c[0] = '0;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
    tcr_div_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[k]),
      .span_i (span_c[k]),
      .rem_i  (rem_c[k]),
      .quot_i (quot_c[k]),
      .ctl_o  (ctl_c[k+1]),
      .span_o (span_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .quot_o (quot_c[k+1])
    );
  end

  tcr_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_c[FRAC_BITS]),
    .quot_i  (quot_c[FRAC_BITS]),
    .done_o  (done_o),
    .color_o (color_rgb565_o)
  );

  `TCR_ASSERT_DLY(a_req_gives_done, clk_i, rst_ni, accept, LATENCY, done_o)
  `TCR_ASSERT(a_done_has_req, clk_i, rst_ni, done_o, $past(accept, LATENCY))
  `TCR_ASSERT_NEXT(a_chain_to_done, clk_i, rst_ni, ctl_c[FRAC_BITS].valid, done_o)

endmodule

[test/temperature_color_ramp_core_tb.sv]
// Self-checking testbench for the temperature to RGB565 color ramp core
`timescale 1ns / 1ps

module temperature_color_ramp_core_tb;

  localparam int FRAC = tcr_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = FRAC + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 170;

  localparam logic [23:0] STOP_BLUE  = {8'd40, 8'd90, 8'd230};
  localparam logic [23:0] STOP_GREEN = {8'd40, 8'd200, 8'd80};
  localparam logic [23:0] STOP_RED   = {8'd210, 8'd40, 8'd30};

  localparam logic [tcr_pkg::COLOR_W-1:0] PIX_BLUE  = 16'h2ADC;
  localparam logic [tcr_pkg::COLOR_W-1:0] PIX_GREEN = 16'h2E4A;
  localparam logic [tcr_pkg::COLOR_W-1:0] PIX_RED   = 16'hD143;

  typedef struct packed {
    logic signed [tcr_pkg::TEMP_W-1:0] scale_low;
    logic signed [tcr_pkg::TEMP_W-1:0] scale_high;
    logic signed [tcr_pkg::TEMP_W-1:0] comfort_low;
    logic signed [tcr_pkg::TEMP_W-1:0] comfort_high;
  } ramp_cfg_t;

  typedef struct packed {
    logic signed [tcr_pkg::TEMP_W-1:0] temperature;
    logic                              known;
    logic [tcr_pkg::COLOR_W-1:0]       color;
  } sample_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start_i = 1'b0;
  logic                                busy_o;
  logic signed [tcr_pkg::TEMP_W-1:0]   temperature_i = '0;
  logic                                done_o;
  logic [tcr_pkg::COLOR_W-1:0]         color_rgb565_o;
  logic                                cfg_we_i = 1'b0;
  logic [tcr_pkg::CFG_IDX_W-1:0]       cfg_idx_i = tcr_pkg::CFG_SCALE_LOW;
  logic [tcr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i = '0;

  ramp_cfg_t live_cfg = '{tcr_pkg::SCALE_LOW_RST, tcr_pkg::SCALE_HIGH_RST,
                          tcr_pkg::COMFORT_LOW_RST, tcr_pkg::COMFORT_HIGH_RST};
  logic [tcr_pkg::COLOR_W-1:0] pending_colors [$];
  logic [tcr_pkg::COLOR_W-1:0] oldest_color;
  int mismatches = 0;
  int colors_checked = 0;
  int requests_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  sample_row_t sample_rows [17] = '{
    '{-16'sd32768, 1'b1, PIX_BLUE},
    '{16'sd32767, 1'b1, PIX_RED},
    '{16'sd0, 1'b1, PIX_BLUE},
    '{-16'sd1, 1'b1, PIX_BLUE},
    '{16'sd1600, 1'b1, PIX_RED},
    '{16'sd1601, 1'b1, PIX_RED},
    '{16'sd1088, 1'b1, PIX_GREEN},
    '{16'sd1089, 1'b1, PIX_GREEN},
    '{16'sd1150, 1'b1, PIX_GREEN},
    '{16'sd1231, 1'b1, PIX_GREEN},
    '{16'sd1232, 1'b1, PIX_GREEN},
    '{16'sd1087, 1'b0, '0},
    '{16'sd1233, 1'b0, '0},
    '{16'sd544, 1'b0, '0},
    '{16'sd1416, 1'b0, '0},
    '{16'sh5555, 1'b1, PIX_RED},
    '{16'shAAAA, 1'b1, PIX_BLUE}
  };

  temperature_color_ramp_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .temperature_i  (temperature_i),
    .done_o         (done_o),
    .color_rgb565_o (color_rgb565_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_to(int x, int lo, int hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint ramp_fraction(int t, int base, int span);
    longint num;
    num = longint'(t) - longint'(base);
    if (span < 1) span = 1;
    if (num <= 0) return 0;
    if (num >= span) return longint'(1) << FRAC;
    return (num << FRAC) / span;
  endfunction

  function automatic logic [tcr_pkg::COLOR_W-1:0] blend_rgb565(logic [23:0] from_stop,
                                                               logic [23:0] to_stop,
                                                               longint f);
    logic [7:0] ch [3];
    longint v;
    int a;
    int b;
    for (int i = 0; i < 3; i++) begin
      a = from_stop[23 - 8*i -: 8];
      b = to_stop[23 - 8*i -: 8];
      v = (longint'(a) << FRAC) + longint'(b - a) * f;
      if (v < 0) v = 0;
      ch[i] = v[FRAC +: 8];
    end
    return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
  endfunction

  function automatic logic [tcr_pkg::COLOR_W-1:0] predict_color(
      logic signed [tcr_pkg::TEMP_W-1:0] temp, ramp_cfg_t c);
    int t;
    int sl;
    int sh;
    int clo;
    int chi;
    t = temp;
    sl = c.scale_low;
    sh = c.scale_high;
    clo = clamp_to(c.comfort_low, sl, sh);
    chi = clamp_to(c.comfort_high, clo, sh);
    if (t <= clo) return blend_rgb565(STOP_BLUE, STOP_GREEN, ramp_fraction(t, sl, clo - sl));
    if (t >= chi) return blend_rgb565(STOP_GREEN, STOP_RED, ramp_fraction(t, chi, sh - chi));
    return blend_rgb565(STOP_GREEN, STOP_GREEN, 0);
  endfunction

  function automatic logic signed [tcr_pkg::TEMP_W-1:0] pick_temperature(ramp_cfg_t c);
    int sel;
    int anchor;
    int lo;
    int hi;
    sel = $urandom_range(0, 99);
    if (sel < 25) return tcr_pkg::TEMP_W'($urandom);
    if (sel < 55) begin
      case ($urandom_range(0, 5))
        0: anchor = c.scale_low;
        1: anchor = c.scale_high;
        2: anchor = c.comfort_low;
        3: anchor = c.comfort_high;
        4: anchor = -32768;
        default: anchor = 32767;
      endcase
      return tcr_pkg::TEMP_W'(anchor + int'($urandom_range(0, 6)) - 3);
    end
    lo = (c.scale_low < c.scale_high) ? c.scale_low : c.scale_high;
    hi = (c.scale_low < c.scale_high) ? c.scale_high : c.scale_low;
    lo = lo - 64;
    hi = hi + 64;
    return tcr_pkg::TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic wait_drained();
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tcr_pkg::CFG_IDX_W-1:0] idx,
                           logic [tcr_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      tcr_pkg::CFG_SCALE_LOW:    live_cfg.scale_low = value;
      tcr_pkg::CFG_SCALE_HIGH:   live_cfg.scale_high = value;
      tcr_pkg::CFG_COMFORT_LOW:  live_cfg.comfort_low = value;
      tcr_pkg::CFG_COMFORT_HIGH: live_cfg.comfort_high = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(ramp_cfg_t s);
    wait_drained();
    write_reg(tcr_pkg::CFG_SCALE_LOW, s.scale_low);
    write_reg(tcr_pkg::CFG_SCALE_HIGH, s.scale_high);
    write_reg(tcr_pkg::CFG_COMFORT_LOW, s.comfort_low);
    write_reg(tcr_pkg::CFG_COMFORT_HIGH, s.comfort_high);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_request(logic signed [tcr_pkg::TEMP_W-1:0] t, logic known,
                              logic [tcr_pkg::COLOR_W-1:0] known_color);
    start_i <= 1'b1;
    temperature_i <= t;
    do @(posedge clk_i); while (busy_o);
    pending_colors.push_back(known ? known_color : predict_color(t, live_cfg));
    requests_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_colors.size() == 0) begin
        $error("color_rgb565: expected none, actual %h", color_rgb565_o);
        mismatches++;
      end else begin
        oldest_color = pending_colors.pop_front();
        colors_checked++;
        if (oldest_color !== color_rgb565_o) begin
          $error("color_rgb565: expected %h, actual %h", oldest_color, color_rgb565_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    ramp_cfg_t s;
    int idle_pct;
    int sl;
    int sh;
    int clo;
    bit pause;
    bit lower;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples at the reset scale
    foreach (sample_rows[i]) begin
      send_request(sample_rows[i].temperature, sample_rows[i].known, sample_rows[i].color);
      if (i == $size(sample_rows) - 1) start_i <= 1'b0;
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: s = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
        1: s = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd0};
        2: s = '{16'sd1000, -16'sd1000, 16'sd0, 16'sd500};
        3: s = '{16'sd100, 16'sd100, 16'sd100, 16'sd100};
        4: s = '{-16'sd500, 16'sd2000, -16'sd32768, 16'sd32767};
        5: s = '{-16'sd200, 16'sd1800, 16'sd900, 16'sd300};
        6: s = '{tcr_pkg::SCALE_LOW_RST, tcr_pkg::SCALE_HIGH_RST,
                 tcr_pkg::COMFORT_LOW_RST, tcr_pkg::COMFORT_HIGH_RST};
        7: s = '{tcr_pkg::TEMP_W'($urandom), tcr_pkg::TEMP_W'($urandom),
                 tcr_pkg::TEMP_W'($urandom), tcr_pkg::TEMP_W'($urandom)};
        default: begin
          sl = int'($urandom_range(0, 1000)) - 500;
          sh = sl + int'($urandom_range(16, 3000));
          clo = sl + int'($urandom_range(0, sh - sl));
          s = '{tcr_pkg::TEMP_W'(sl), tcr_pkg::TEMP_W'(sh), tcr_pkg::TEMP_W'(clo),
                tcr_pkg::TEMP_W'(clo + int'($urandom_range(0, sh - clo)))};
        end
      endcase
      apply_settings(s);
      idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 59 : 7);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(pick_temperature(live_cfg), 1'b0, '0);
        pause = (n == 80) && (phase == 2 || phase == 5);
        lower = pause || (n == ITEMS_PER_PHASE - 1) || ($urandom_range(0, 99) < idle_pct);
        if (lower) begin
          start_i <= 1'b0;
          // on a pause, hold off until the pipeline is empty; else stay idle at random
          if (pause) wait_drained();
          else do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
        end
      end
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_colors.size() != 0) begin
      $error("color_rgb565: %0d expected colors never arrived", pending_colors.size());
      mismatches++;
    end

    $display("Covered %0d temperature requests, %0d colors checked, %0d register settings",
             requests_sent, colors_checked, settings_applied + 1);
    $display("Settings included full-range, inverted, collapsed and out-of-scale bands");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[temperature_color_ramp_core.f]
+incdir+hdl
hdl/tcr_pkg.sv
hdl/tcr_div_cell.sv
hdl/tcr_prep.sv
hdl/tcr_mix.sv
hdl/temperature_color_ramp_core.sv
test/temperature_color_ramp_core_tb.sv
